>>> design/segment_sphere_intersect_defines.svh
// Assertion macros used by the checker file.
`ifndef SEGMENT_SPHERE_INTERSECT_DEFINES_SVH
`define SEGMENT_SPHERE_INTERSECT_DEFINES_SVH
// Property under an active-low reset.
`define SSI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Property checked at every edge, reset included.
`define SSI_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`endif

>>> design/ssi_pkg.sv
// ----------------------------------------------------------------------------
// ssi_pkg
// Shared types and constants of the segment and sphere hit test.
// ----------------------------------------------------------------------------
package ssi_pkg;
  localparam int unsigned FracBits = 16;
  localparam int unsigned CoordW  = 32;
  localparam int unsigned RadW    = 31;
  localparam int unsigned TW      = 17;
  localparam int unsigned TBits   = 16;
  localparam int unsigned DiffW   = 34;
  localparam int unsigned ScW     = 16;   // scaled values: magnitude below 2^15
  localparam int unsigned DiscW   = 64;
  localparam int unsigned RootW   = 32;
  localparam int unsigned AW      = 34;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [DiffW-1:0]  diff_t;
endpackage

>>> design/segment_sphere_intersect.sv
// A word passes stages 1 to 4, the root steps, stage 5, the divider steps and stages 6 and 7.
// Throughput: one word a cycle while the output is not stalled; the 32-step root and
// the 50-step divider are fully unrolled register stages and set the depth.
// A stall on the output freezes the whole pipeline, nothing is lost.
// Reset clears only the valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// segment_sphere_intersect
// Pipelined segment against sphere hit test in signed fixed point.
// ----------------------------------------------------------------------------
module segment_sphere_intersect (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  ssi_pkg::coord_t            start_x_i,
  input  ssi_pkg::coord_t            start_y_i,
  input  ssi_pkg::coord_t            start_z_i,
  input  ssi_pkg::coord_t            end_x_i,
  input  ssi_pkg::coord_t            end_y_i,
  input  ssi_pkg::coord_t            end_z_i,
  input  ssi_pkg::coord_t            center_x_i,
  input  ssi_pkg::coord_t            center_y_i,
  input  ssi_pkg::coord_t            center_z_i,
  input  logic [ssi_pkg::RadW-1:0]   sphere_radius_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       hit_o,
  output logic [ssi_pkg::TW-1:0]     hit_param_o,
  output ssi_pkg::coord_t            hit_x_o,
  output ssi_pkg::coord_t            hit_y_o,
  output ssi_pkg::coord_t            hit_z_o
);
  import ssi_pkg::*;

  localparam logic [63:0] NearZero =
    64'(((64'd1 << (2 * FracBits)) + 64'd999999) / 64'd1000000);
  localparam int unsigned NSq  = 32;
  localparam int unsigned NDiv = 50;  // quotient of (n << 16) / a, n << 16 below 2^50

  // Global enable: the pipeline advances unless a held result is stalled
  logic en;
  assign en = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // -------------------- stage 1: differences, magnitudes --------------------
  diff_t       d1_q [3];
  diff_t       m1_q [3];
  coord_t      s1_q [3];
  logic [30:0] r1_q;
  coord_t      st_in [3], en_in [3], ce_in [3];

  assign st_in = '{start_x_i, start_y_i, start_z_i};
  assign en_in = '{end_x_i, end_y_i, end_z_i};
  assign ce_in = '{center_x_i, center_y_i, center_z_i};

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d1_q[i] <= DiffW'(en_in[i]) - DiffW'(st_in[i]);
        m1_q[i] <= DiffW'(st_in[i]) - DiffW'(ce_in[i]);
        s1_q[i] <= st_in[i];
      end
      r1_q <= sphere_radius_i;
    end
  end

  function automatic logic [DiffW-1:0] mag(input diff_t v);
    mag = v[DiffW-1] ? DiffW'(-v) : DiffW'(v);
  endfunction

  // -------------------- stage 2: shift amount, near-zero test ---------------
  logic        degen2_q;
  logic [5:0]  sh2_q;
  diff_t       d2_q [3];
  diff_t       m2_q [3];
  coord_t      s2_q [3];
  logic [30:0] r2_q;
  logic [DiffW-1:0] big;
  logic [5:0]  shc;
  logic        short_seg;
  logic [63:0] a0;
  logic [DiffW-1:0] dmag;
  logic [39:0] dsq;

  always_comb begin
    big = DiffW'(r1_q);
    short_seg = 1'b1;
    a0 = '0;
    for (int i = 0; i < 3; i++) begin
      if (mag(d1_q[i]) > big) big = mag(d1_q[i]);
      if (mag(m1_q[i]) > big) big = mag(m1_q[i]);
      if (mag(d1_q[i]) >= DiffW'(1 << 20)) short_seg = 1'b0;
      // only needed for a short segment, where every magnitude fits 20 bits
      dmag = mag(d1_q[i]);
      dsq = dmag[19:0] * dmag[19:0];
      a0 = a0 + 64'(dsq);
    end
    shc = '0;
    for (int k = 1; k <= 20; k++) begin
      if ((big >> (k - 1)) >= DiffW'(32768)) shc = 6'(k);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sh2_q <= shc;
      degen2_q <= short_seg && (a0 < NearZero);
      d2_q <= d1_q;
      m2_q <= m1_q;
      s2_q <= s1_q;
      r2_q <= r1_q;
    end
  end

  // -------------------- stage 3: scale, products ----------------------------
  logic signed [ScW-1:0] ds [3], ms [3];
  logic        [ScW-1:0] rsc;
  logic signed [63:0] p_a, p_h, p_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ds[i] = d2_q[i][DiffW-1] ? -ScW'(mag(d2_q[i]) >> sh2_q)
                               :  ScW'(mag(d2_q[i]) >> sh2_q);
      ms[i] = m2_q[i][DiffW-1] ? -ScW'(mag(m2_q[i]) >> sh2_q)
                               :  ScW'(mag(m2_q[i]) >> sh2_q);
    end
    rsc = ScW'(r2_q >> sh2_q);
    p_a = '0;
    p_h = '0;
    p_c = -64'($signed({1'b0, rsc}) * $signed({1'b0, rsc}));
    for (int i = 0; i < 3; i++) begin
      p_a = p_a + 64'(ds[i] * ds[i]);
      p_h = p_h + 64'(ms[i] * ds[i]);
      p_c = p_c + 64'(ms[i] * ms[i]);
    end
  end

  logic               degen3_q;
  logic signed [63:0] a3_q, h3_q, c3_q;
  diff_t              d3_q [3];
  coord_t             s3_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      a3_q <= p_a; h3_q <= p_h; c3_q <= p_c;
      degen3_q <= degen2_q;
      d3_q <= d2_q; s3_q <= s2_q;
    end
  end

  // -------------------- stage 4: discriminant -------------------------------
  logic               miss4_q;
  logic signed [63:0] a4_q, h4_q, disc4_q;
  diff_t              d4_q [3];
  coord_t             s4_q [3];
  logic signed [63:0] disc_c;
  logic signed [33:0] a34, h34, c34;
  logic signed [67:0] hh, ac;

  // a, h and c all fit 34 signed bits; the true discriminant fits 64
  assign a34 = a3_q[33:0];
  assign h34 = h3_q[33:0];
  assign c34 = c3_q[33:0];
  assign hh = h34 * h34;
  assign ac = a34 * c34;
  assign disc_c = 64'(hh - ac);

  always_ff @(posedge clk_i) begin
    if (en) begin
      disc4_q <= disc_c;
      miss4_q <= degen3_q || (a3_q == 0) || disc_c[63];
      a4_q <= a3_q; h4_q <= h3_q;
      d4_q <= d3_q; s4_q <= s3_q;
    end
  end

  // -------------------- square root pipeline --------------------------------
  logic [63:0] sq_rem [NSq+1];
  logic [63:0] sq_res [NSq+1];
  logic               sq_miss_q [NSq];
  logic signed [63:0] sq_a_q [NSq], sq_h_q [NSq];
  diff_t              sq_d_q [NSq][3];
  coord_t             sq_s_q [NSq][3];

  assign sq_rem[0] = disc4_q[63] ? '0 : disc4_q;
  assign sq_res[0] = '0;

  for (genvar g = 0; g < NSq; g++) begin : g_sq
    ssi_sqrt_stage #(.Step(g)) u_sq (
      .clk_i, .en_i(en), .rem_i(sq_rem[g]), .res_i(sq_res[g]),
      .rem_o(sq_rem[g+1]), .res_o(sq_res[g+1])
    );
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (g == 0) begin
          sq_miss_q[g] <= miss4_q; sq_a_q[g] <= a4_q; sq_h_q[g] <= h4_q;
          sq_d_q[g] <= d4_q; sq_s_q[g] <= s4_q;
        end else begin
          sq_miss_q[g] <= sq_miss_q[g-1]; sq_a_q[g] <= sq_a_q[g-1];
          sq_h_q[g] <= sq_h_q[g-1]; sq_d_q[g] <= sq_d_q[g-1];
          sq_s_q[g] <= sq_s_q[g-1];
        end
      end
    end
  end

  // -------------------- stage 5: root choice --------------------------------
  logic               miss5_q;
  logic [AW-1:0]      a5_q;
  logic [AW-1:0]      n5_q;
  diff_t              d5_q [3];
  coord_t             s5_q [3];
  logic signed [65:0] n1, n2, aw;
  logic               ok1, ok2;

  always_comb begin
    aw = 66'(sq_a_q[NSq-1]);
    n1 = -66'(sq_h_q[NSq-1]) - 66'(sq_res[NSq]);
    n2 = -66'(sq_h_q[NSq-1]) + 66'(sq_res[NSq]);
    ok1 = !n1[65] && (n1 <= aw);
    ok2 = !n2[65] && (n2 <= aw);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      miss5_q <= sq_miss_q[NSq-1] || (!ok1 && !ok2);
      n5_q <= ok1 ? AW'(n1) : AW'(n2);
      a5_q <= AW'(sq_a_q[NSq-1]);
      d5_q <= sq_d_q[NSq-1]; s5_q <= sq_s_q[NSq-1];
    end
  end

  // -------------------- division pipeline -----------------------------------
  // numerator n << 16 is 50 bits; feed its bits from the top
  logic [49:0] dn_q [NDiv];
  logic [35:0] dv_rem [NDiv+1];
  logic [16:0] dv_quo [NDiv+1];
  logic [AW-1:0] dv_a_q [NDiv];
  logic          dv_miss_q [NDiv];
  diff_t         dv_d_q [NDiv][3];
  coord_t        dv_s_q [NDiv][3];
  logic [49:0]   num_full;

  assign num_full = {n5_q[AW-1:0], 16'd0};
  assign dv_rem[0] = '0;
  assign dv_quo[0] = '0;

  for (genvar g = 0; g < NDiv; g++) begin : g_dv
    logic [49:0]   nsrc;
    logic [AW-1:0] asrc;
    assign nsrc = (g == 0) ? num_full : dn_q[g-1];
    assign asrc = (g == 0) ? a5_q : dv_a_q[g-1];
    ssi_div_stage u_dv (
      .clk_i, .en_i(en), .rem_i(dv_rem[g]), .den_i(asrc), .quo_i(dv_quo[g]),
      .nbit_i(nsrc[49 - g]),
      .rem_o(dv_rem[g+1]), .quo_o(dv_quo[g+1])
    );
    always_ff @(posedge clk_i) begin
      if (en) begin
        dn_q[g] <= nsrc; dv_a_q[g] <= asrc;
        dv_miss_q[g] <= (g == 0) ? miss5_q : dv_miss_q[g-1];
        dv_d_q[g] <= (g == 0) ? d5_q : dv_d_q[g-1];
        dv_s_q[g] <= (g == 0) ? s5_q : dv_s_q[g-1];
      end
    end
  end

  // -------------------- stage 6: d * t products -----------------------------
  logic               miss6_q;
  logic [16:0]        t6_q;
  logic signed [51:0] p6_q [3];
  coord_t             s6_q [3];
  logic [16:0]        tq;

  // n never exceeds a, so the quotient is at most 2^16 and fits the low bits
  assign tq = dv_quo[NDiv];

  always_ff @(posedge clk_i) begin
    if (en) begin
      miss6_q <= dv_miss_q[NDiv-1];
      t6_q <= tq;
      for (int i = 0; i < 3; i++) begin
        p6_q[i] <= 52'(dv_d_q[NDiv-1][i]) * $signed({35'd0, tq});
      end
      s6_q <= dv_s_q[NDiv-1];
    end
  end

  // -------------------- stage 7: round, add, saturate -----------------------
  logic signed [51:0] rq [3];
  logic signed [52:0] sum [3];
  coord_t             pt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // floor((p + half) / 2^16) equals rounding halves toward +infinity
      rq[i] = (p6_q[i] + 52'sd32768) >>> TBits;
      sum[i] = 53'(s6_q[i]) + 53'(rq[i]);
      if (sum[i] > 53'sd2147483647) pt[i] = 32'sh7fffffff;
      else if (sum[i] < -53'sd2147483648) pt[i] = 32'sh80000000;
      else pt[i] = coord_t'(sum[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_o       <= !miss6_q;
      hit_param_o <= miss6_q ? '0 : t6_q;
      hit_x_o     <= miss6_q ? '0 : pt[0];
      hit_y_o     <= miss6_q ? '0 : pt[1];
      hit_z_o     <= miss6_q ? '0 : pt[2];
    end
  end

  // -------------------- valid chain -----------------------------------------
  localparam int unsigned Depth = 4 + NSq + 1 + NDiv + 2;
  logic [Depth-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  assign out_valid_o = vld_q[Depth-1];
endmodule

>>> design/ssi_sqrt_stage.sv
// ----------------------------------------------------------------------------
// ssi_sqrt_stage
// One registered step of the restoring square root.
// ----------------------------------------------------------------------------
module ssi_sqrt_stage #(
  parameter int unsigned Step = 0
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] rem_i,
  input  logic [63:0] res_i,
  output logic [63:0] rem_o,
  output logic [63:0] res_o
);
  import ssi_pkg::*;

  localparam logic [63:0] Bit = 64'd1 << (62 - 2 * Step);

  logic [63:0] rem_d, res_d, rem_q, res_q;

  // Try the next bit and keep it where the remainder allows
  always_comb begin
    if (rem_i >= res_i + Bit) begin
      rem_d = rem_i - (res_i + Bit);
      res_d = (res_i >> 1) + Bit;
    end else begin
      rem_d = rem_i;
      res_d = res_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      res_q <= res_d;
    end
  end

  assign rem_o = rem_q;
  assign res_o = res_q;
endmodule

>>> design/ssi_div_stage.sv
// ----------------------------------------------------------------------------
// ssi_div_stage
// One registered step of the restoring divider, one quotient bit a step.
// ----------------------------------------------------------------------------
module ssi_div_stage (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [35:0] rem_i,
  input  logic [33:0] den_i,
  input  logic [16:0] quo_i,
  input  logic        nbit_i,
  output logic [35:0] rem_o,
  output logic [16:0] quo_o
);
  import ssi_pkg::*;

  logic [35:0] sh;
  logic [35:0] rem_d, rem_q;
  logic [16:0] quo_d, quo_q;

  // Shift in the next numerator bit and subtract where it fits
  always_comb begin
    sh = {rem_i[34:0], nbit_i};
    if (sh >= {2'b00, den_i}) begin
      rem_d = sh - {2'b00, den_i};
      quo_d = {quo_i[15:0], 1'b1};
    end else begin
      rem_d = sh;
      quo_d = {quo_i[15:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign rem_o = rem_q;
  assign quo_o = quo_q;
endmodule

>>> design/ssi_checker.sv
// ----------------------------------------------------------------------------
// ssi_checker
// Port-level checks of the hit test, bound to the top level.
// ----------------------------------------------------------------------------
`include "segment_sphere_intersect_defines.svh"
module ssi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        hit_o,
  input logic [16:0] hit_param_o,
  input logic [31:0] hit_x_o
);
  `SSI_ASSERT(a_miss_zero, out_valid_o && !hit_o |-> hit_param_o == 17'd0 && hit_x_o == 32'd0, "miss word not zeroed")
  `SSI_ASSERT(a_t_range, out_valid_o && hit_o |-> hit_param_o <= 17'd65536, "t above one")
  `SSI_ASSERT(a_stall_link, in_stall_o == (out_valid_o && out_stall_i), "input stall not tied to held output")
  `SSI_ASSERT(a_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(hit_param_o), "stalled word changed")
  `SSI_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o || rst_ni, "output valid after reset")
endmodule

bind segment_sphere_intersect ssi_checker u_ssi_checker (.*);

>>> sim/segment_sphere_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_sphere_checker
// Watches both channels of the hit test, works out the expected hit word for
// every accepted segment and compares each result word field by field.
// ----------------------------------------------------------------------------
module segment_sphere_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  ssi_pkg::coord_t          start_x_i,
  input  ssi_pkg::coord_t          start_y_i,
  input  ssi_pkg::coord_t          start_z_i,
  input  ssi_pkg::coord_t          end_x_i,
  input  ssi_pkg::coord_t          end_y_i,
  input  ssi_pkg::coord_t          end_z_i,
  input  ssi_pkg::coord_t          center_x_i,
  input  ssi_pkg::coord_t          center_y_i,
  input  ssi_pkg::coord_t          center_z_i,
  input  logic [ssi_pkg::RadW-1:0] sphere_radius_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic                     hit_i,
  input  logic [ssi_pkg::TW-1:0]   hit_param_i,
  input  ssi_pkg::coord_t          hit_x_i,
  input  ssi_pkg::coord_t          hit_y_i,
  input  ssi_pkg::coord_t          hit_z_i,
  output int                       fail_count_o,
  output int                       pending_o
);
  import ssi_pkg::*;

  typedef struct packed {
    logic          hit;
    logic [TW-1:0] t;
    coord_t        px;
    coord_t        py;
    coord_t        pz;
  } hit_word_t;

  localparam longint unsigned NearZero = ((64'd1 << 32) + 64'd999999) / 64'd1000000;

  hit_word_t expected_hits[$];

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint shrink(longint v, int s);
    longint unsigned q;
    q = mag(v) >> s;
    return v < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Round p / 2^16 with halves toward +infinity, then saturate onto start.
  function automatic coord_t place(longint st, longint p);
    longint q, v;
    q = p + 32768;
    if (q >= 0) q = longint'(longint'(unsigned'(q)) >>> 16);
    else q = -longint'((mag(q) + 65535) >> 16);
    v = st + q;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return coord_t'(v);
  endfunction

  function automatic hit_word_t predict_hit(longint st[3], longint en[3], longint ce[3],
                                            longint unsigned rad);
    hit_word_t w;
    longint d[3], m[3], ds, ms, a, h, c, rs, disc, root, num;
    longint unsigned big, a0, tq;
    int s;
    bit short_seg;
    w = '0;
    short_seg = 1;
    for (int i = 0; i < 3; i++) begin
      d[i] = en[i] - st[i];
      m[i] = st[i] - ce[i];
      if (mag(d[i]) >= (64'd1 << 20)) short_seg = 0;
    end
    // Degenerate segment: too short to test
    if (short_seg) begin
      a0 = 0;
      for (int i = 0; i < 3; i++) a0 += mag(d[i]) * mag(d[i]);
      if (a0 < NearZero) return w;
    end
    big = rad;
    for (int i = 0; i < 3; i++) begin
      if (mag(d[i]) > big) big = mag(d[i]);
      if (mag(m[i]) > big) big = mag(m[i]);
    end
    s = 0;
    while (big >= 32768) begin
      big >>= 1;
      s++;
    end
    a = 0; h = 0; c = 0;
    for (int i = 0; i < 3; i++) begin
      ds = shrink(d[i], s);
      ms = shrink(m[i], s);
      a += ds * ds;
      h += ms * ds;
      c += ms * ms;
    end
    rs = longint'(rad >> s);
    c -= rs * rs;
    if (a == 0) return w;
    disc = h * h - a * c;
    if (disc < 0) return w;
    root = longint'(int_sqrt(longint'(disc)));
    num = -h - root;
    if (num < 0 || num > a) num = -h + root;
    if (num < 0 || num > a) return w;
    tq = (longint'(num) << 16) / longint'(a);
    w.hit = 1'b1;
    w.t = tq[TW-1:0];
    w.px = place(st[0], d[0] * longint'(tq));
    w.py = place(st[1], d[1] * longint'(tq));
    w.pz = place(st[2], d[2] * longint'(tq));
    return w;
  endfunction

  assign pending_o = expected_hits.size();

  // Predict on each accepted segment, compare each accepted result
  always @(posedge clk_i) begin
    hit_word_t want, got;
    longint st[3], en[3], ce[3];
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        st = '{start_x_i, start_y_i, start_z_i};
        en = '{end_x_i, end_y_i, end_z_i};
        ce = '{center_x_i, center_y_i, center_z_i};
        expected_hits.push_back(predict_hit(st, en, ce, longint'(sphere_radius_i)));
      end
      if (out_valid_i && !out_stall_i) begin
        got = '{hit_i, hit_param_i, hit_x_i, hit_y_i, hit_z_i};
        if (expected_hits.size() == 0) begin
          $display("%0t: result word with nothing expected: %h", $realtime, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_hits.pop_front();
          if (want.hit !== got.hit || want.t !== got.t || want.px !== got.px ||
              want.py !== got.py || want.pz !== got.pz) begin
            $display("%0t: mismatch expected hit=%b t=%0d p=(%0d,%0d,%0d) actual hit=%b t=%0d p=(%0d,%0d,%0d)",
                     $realtime, want.hit, want.t, want.px, want.py, want.pz,
                     got.hit, got.t, got.px, got.py, got.pz);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random segment and sphere words into the hit test
// under several idling phases; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import ssi_pkg::*;

  localparam int RandomWords = 1030;
  localparam int DrainCycles = 200;
  localparam int WatchdogLimit = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  coord_t start_x_i = '0, start_y_i = '0, start_z_i = '0;
  coord_t end_x_i = '0, end_y_i = '0, end_z_i = '0;
  coord_t center_x_i = '0, center_y_i = '0, center_z_i = '0;
  logic [RadW-1:0] sphere_radius_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic hit_o;
  logic [TW-1:0] hit_param_o;
  coord_t hit_x_o, hit_y_o, hit_z_o;
  int fail_count, pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  segment_sphere_intersect dut (.*);

  segment_sphere_checker checker_inst (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o),
    .start_x_i, .start_y_i, .start_z_i, .end_x_i, .end_y_i, .end_z_i,
    .center_x_i, .center_y_i, .center_z_i, .sphere_radius_i,
    .out_valid_i(out_valid_o), .out_stall_i, .hit_i(hit_o), .hit_param_i(hit_param_o),
    .hit_x_i(hit_x_o), .hit_y_i(hit_y_o), .hit_z_i(hit_z_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Stall the result side at random
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: count cycles with no accepted word
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("segment_sphere_intersect verification failed");
      $finish;
    end
  end

  function automatic coord_t near_value(int span);
    return coord_t'($urandom_range(2 * span) - span);
  endfunction

  // Hand one word to the block and hold it until accepted
  task automatic send_segment(coord_t sx, coord_t sy, coord_t sz, coord_t ex, coord_t ey,
                              coord_t ez, coord_t cx, coord_t cy, coord_t cz,
                              logic [RadW-1:0] r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    start_x_i <= sx; start_y_i <= sy; start_z_i <= sz;
    end_x_i <= ex; end_y_i <= ey; end_z_i <= ez;
    center_x_i <= cx; center_y_i <= cy; center_z_i <= cz;
    sphere_radius_i <= r;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Mostly segments passing near a sphere, some of zero length, some raw noise
  task automatic send_random();
    coord_t s[3], e[3], c[3];
    logic [RadW-1:0] r;
    int span, kind;
    kind = $urandom_range(9);
    span = 1 << $urandom_range(26, 12);
    for (int i = 0; i < 3; i++) begin
      c[i] = $urandom;
      if (kind < 2) begin
        s[i] = $urandom; e[i] = $urandom;
      end else begin
        s[i] = c[i] + near_value(span);
        e[i] = c[i] + near_value(span);
      end
    end
    r = (kind < 2) ? RadW'($urandom) : RadW'($urandom_range(span, 0));
    if (kind == 2) e = s;
    send_segment(s[0], s[1], s[2], e[0], e[1], e[2], c[0], c[1], c[2], r);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: head-on hit, tangent, miss, inside start, zero length, extremes
    send_segment(-32'sh20000, 0, 0, 32'sh20000, 0, 0, 0, 0, 0, 31'h10000);
    send_segment(-32'sh20000, 32'sh10000, 0, 32'sh20000, 32'sh10000, 0, 0, 0, 0, 31'h10000);
    send_segment(-32'sh20000, 32'sh30000, 0, 32'sh20000, 32'sh30000, 0, 0, 0, 0, 31'h10000);
    send_segment(0, 0, 0, 32'sh40000, 0, 0, 0, 0, 0, 31'h10000);
    send_segment(32'sh50000, 0, 0, 32'sh40000, 0, 0, 0, 0, 0, 31'h10000);
    send_segment(32'sh30000, 0, 0, 32'sh20000, 0, 0, 0, 0, 0, 31'h10000);
    send_segment(32'sh12345, 7, 9, 32'sh12345, 7, 9, 32'sh12345, 7, 9, 31'h100);
    send_segment(5, 5, 5, 6, 5, 5, 0, 0, 0, 31'h100);
    send_segment(0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
    send_segment(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                 32'h7fffffff, 0, 0, 0, 31'h7fffffff);
    send_segment(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                 32'h80000000, 32'h7fffffff, 32'h80000000, 0, 31'h7fffffff);
    send_segment(32'h80000000, 0, 32'h7fffffff, 32'h80000000, 0, 32'h7fffffff,
                 32'h80000000, 32'h7fffffff, 0, 31'h7fffffff);
    send_segment(32'h7ff00000, 0, 0, 32'h7fff0000, 0, 0, 32'h7ffe0000, 0, 0, 31'h40000000);
    send_segment(0, 0, 0, 32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0, 31'h7fffffff);
    send_segment(32'sh100, 0, 0, -32'sh100, 0, 0, 0, 0, 0, 31'h80);
    send_segment(0, 32'sh8000, 0, 0, -32'sh8000, 0, 0, 0, 0, 31'h4000);

    // Random phases: none, sender idle, receiver stalling, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 75 : (ph == 3) ? 11 : 0;
      recv_stall_pct = (ph == 2) ? 75 : (ph == 3) ? 11 : 0;
      for (int n = 0; n < RandomWords / 4; n++) send_random();
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("segment_sphere_intersect verification clean");
    end else begin
      $display("segment_sphere_intersect verification failed");
    end
    $finish;
  end
endmodule
